// File: design/event_report_queue_macros.svh
// Assertion macros for the event report queue.
`ifndef EVENT_REPORT_QUEUE_MACROS_SVH
`define EVENT_REPORT_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ERQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ERQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ERQ_ASSERT_SAME(label, ante, cons, msg)

`define ERQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/erq_pkg.sv
package erq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_DISC = 2'd1;
    localparam logic [1:0] FUNC_POLL = 2'd2;

    localparam logic [1:0] CFG_DROPPABLE = 2'd0;
    localparam logic [1:0] CFG_PRIORITY  = 2'd1;
    localparam logic [1:0] CFG_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  report_id;
        logic [7:0]  report_flags;
        logic [63:0] report_payload;
        logic [3:0]  report_length;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic        out_valid;
        logic [7:0]  out_id;
        logic [7:0]  out_flags;
        logic [7:0]  out_seq;
        logic [63:0] out_payload;
        logic [3:0]  out_length;
        logic [3:0]  free_slots;
    } t_res;

    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  length;
        logic [7:0]  flags;
        logic [7:0]  id;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISC_RD,
        S_DISC_CHK,
        S_PUSH,
        S_DROP_RD,
        S_DROP_CHK,
        S_POLL,
        S_POLL_OUT
    } t_state;

endpackage

// File: design/erq_ram.sv
module erq_ram #(
    parameter int WIDTH = 84,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: design/event_report_queue.sv
// Event report queue: a bounded FIFO of reports with id, flags, payload, length.
// Request channel: i_req is taken at a rising edge with i_start high and o_busy
// low. Each request gives exactly one result on o_res, shown for one cycle with
// o_res_valid high; the receiver cannot hold it off.
// Configuration: i_cfg_valid writes i_cfg_data into the mask at i_cfg_index;
// o_cfg_ready is always high. Write masks only while o_busy is low.
// Steps: a push writes a free slot in S_PUSH. A push on a full queue with a
// priority flag walks the queue for the oldest droppable report, frees it and
// pushes again. A discard push first frees every queued report with its id,
// then pushes. A poll passes S_POLL and then S_POLL_OUT (only S_POLL when the
// queue is empty). An unused function code is answered from S_IDLE.
// The walks read the slot memory one entry at a time, in a read state and a
// compare state, so the longest request is a discard walk on a full queue
// followed by a fruitless priority walk.
// Reset empties the queue, clears the overflow flag and sequence number and
// restores the masks to droppable 1, priority 2, overflow 4. The slot memory
// needs no clearing.
module event_report_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  erq_pkg::t_req i_req,
    output logic          o_res_valid,
    output erq_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);

    localparam int DEPTH = erq_pkg::QUEUE_DEPTH;
    localparam int SW    = erq_pkg::SLOT_W;
    localparam int CW    = erq_pkg::CNT_W;

    erq_pkg::t_state r_state, n_state;
    erq_pkg::t_req   r_req;
    erq_pkg::t_res   r_res, n_res;
    logic            r_res_valid, n_res_valid;
    logic [CW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_free, n_free;
    logic [DEPTH-1:0] r_busy, n_busy;
    logic [SW-1:0]   r_order [DEPTH];
    logic [SW-1:0]   n_order [DEPTH];
    logic            r_held_valid, n_held_valid;
    logic [SW-1:0]   r_held, n_held;
    logic            r_ovf, n_ovf;
    logic [7:0]      r_seq, n_seq;
    logic [7:0]      r_dmask, r_pmask, r_omask;

    logic            accept;
    logic            wr_en;
    logic [SW-1:0]   rd_addr;
    logic [SW-1:0]   free_slot;
    erq_pkg::t_slot  wr_data, rd_data;
    logic            rel_en, shift_en;
    logic [SW-1:0]   rel_slot;
    logic [CW-1:0]   shift_pos;
    logic [CW:0]     slot_sum;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != erq_pkg::S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;
    assign o_cfg_ready = 1'b1;
    assign rd_addr     = r_order[r_k[SW-1:0]];
    assign slot_sum    = {1'b0, r_free} + {1'b0, r_count};

    assign wr_data.payload = r_req.report_payload;
    assign wr_data.length  = r_req.report_length;
    assign wr_data.flags   = r_req.report_flags;
    assign wr_data.id      = r_req.report_id;

    erq_ram #(
        .WIDTH ($bits(erq_pkg::t_slot)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_slot),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            erq_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.func)
                        erq_pkg::FUNC_PUSH: n_state = erq_pkg::S_PUSH;
                        erq_pkg::FUNC_DISC: n_state = erq_pkg::S_DISC_RD;
                        erq_pkg::FUNC_POLL: n_state = erq_pkg::S_POLL;
                        default:            n_state = erq_pkg::S_IDLE;
                    endcase
                end
            end
            erq_pkg::S_DISC_RD:
                n_state = (r_k < r_count) ? erq_pkg::S_DISC_CHK : erq_pkg::S_PUSH;
            erq_pkg::S_DISC_CHK:
                n_state = erq_pkg::S_DISC_RD;
            erq_pkg::S_PUSH: begin
                if (r_free == '0 && (r_req.report_flags & r_pmask) != '0) begin
                    n_state = erq_pkg::S_DROP_RD;
                end else begin
                    n_state = erq_pkg::S_IDLE;
                end
            end
            erq_pkg::S_DROP_RD:
                n_state = (r_k < r_count) ? erq_pkg::S_DROP_CHK : erq_pkg::S_IDLE;
            erq_pkg::S_DROP_CHK: begin
                if ((rd_data.flags & r_dmask) != '0) begin
                    n_state = erq_pkg::S_PUSH;
                end else begin
                    n_state = erq_pkg::S_DROP_RD;
                end
            end
            erq_pkg::S_POLL:
                n_state = (r_count != '0) ? erq_pkg::S_POLL_OUT : erq_pkg::S_IDLE;
            erq_pkg::S_POLL_OUT:
                n_state = erq_pkg::S_IDLE;
            default:
                n_state = erq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_res        = '0;
        n_res_valid  = 1'b0;
        n_k          = r_k;
        n_count      = r_count;
        n_free       = r_free;
        n_busy       = r_busy;
        n_order      = r_order;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_ovf        = r_ovf;
        n_seq        = r_seq;
        wr_en        = 1'b0;
        rel_en       = 1'b0;
        rel_slot     = rd_addr;
        shift_en     = 1'b0;
        shift_pos    = r_k;
        case (r_state)
            erq_pkg::S_IDLE: begin
                n_k = '0;
                if (accept && i_req.func != erq_pkg::FUNC_PUSH
                    && i_req.func != erq_pkg::FUNC_DISC
                    && i_req.func != erq_pkg::FUNC_POLL) begin
                    n_res_valid = 1'b1;
                end
            end
            erq_pkg::S_DISC_CHK: begin
                if (rd_data.id == r_req.report_id) begin
                    rel_en   = 1'b1;
                    shift_en = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            erq_pkg::S_PUSH: begin
                if (r_free != '0) begin
                    wr_en                       = 1'b1;
                    n_busy[free_slot]           = 1'b1;
                    n_free                      = r_free - 1'b1;
                    n_order[r_count[SW-1:0]]    = free_slot;
                    n_count                     = r_count + 1'b1;
                    n_res.accepted              = 1'b1;
                    n_res_valid                 = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                    n_k   = '0;
                    if ((r_req.report_flags & r_pmask) == '0) begin
                        n_res_valid = 1'b1;
                    end
                end
            end
            erq_pkg::S_DROP_RD: begin
                if (r_k >= r_count) begin
                    n_res_valid = 1'b1;
                end
            end
            erq_pkg::S_DROP_CHK: begin
                if ((rd_data.flags & r_dmask) != '0) begin
                    rel_en   = 1'b1;
                    shift_en = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            erq_pkg::S_POLL: begin
                if (r_held_valid) begin
                    rel_en       = 1'b1;
                    rel_slot     = r_held;
                    n_held_valid = 1'b0;
                end
                if (r_count != '0) begin
                    shift_en     = 1'b1;
                    shift_pos    = '0;
                    n_held       = r_order[0];
                    n_held_valid = 1'b1;
                end else begin
                    n_res_valid = 1'b1;
                end
            end
            erq_pkg::S_POLL_OUT: begin
                n_res.out_valid   = 1'b1;
                n_res.out_id      = rd_data.id;
                n_res.out_flags   = r_ovf ? (rd_data.flags | r_omask) : rd_data.flags;
                n_res.out_seq     = r_seq;
                n_res.out_payload = rd_data.payload;
                n_res.out_length  = rd_data.length;
                n_res_valid       = 1'b1;
                n_ovf             = 1'b0;
                n_seq             = r_seq + 1'b1;
            end
            default: begin
            end
        endcase
        if (rel_en && r_busy[rel_slot]) begin
            n_busy[rel_slot] = 1'b0;
            n_free           = r_free + 1'b1;
        end
        if (shift_en) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (CW'(i) >= shift_pos) begin
                    n_order[i] = r_order[i + 1];
                end
            end
            n_count = r_count - 1'b1;
        end
        n_res.free_slots = 4'(n_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= erq_pkg::S_IDLE;
            r_res_valid  <= 1'b0;
            r_k          <= '0;
            r_count      <= '0;
            r_free       <= CW'(DEPTH);
            r_busy       <= '0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
            r_ovf        <= 1'b0;
            r_seq        <= '0;
        end else begin
            r_state      <= n_state;
            r_res_valid  <= n_res_valid;
            r_k          <= n_k;
            r_count      <= n_count;
            r_free       <= n_free;
            r_busy       <= n_busy;
            r_held_valid <= n_held_valid;
            r_held       <= n_held;
            r_ovf        <= n_ovf;
            r_seq        <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_order <= n_order;
        if (accept) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmask <= 8'd1;
            r_pmask <= 8'd2;
            r_omask <= 8'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                erq_pkg::CFG_DROPPABLE: r_dmask <= i_cfg_data;
                erq_pkg::CFG_PRIORITY:  r_pmask <= i_cfg_data;
                erq_pkg::CFG_OVERFLOW:  r_omask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

`include "event_report_queue_macros.svh"

    `ERQ_ASSERT_SAME(a_slot_budget, 1'b1, slot_sum <= (CW + 1)'(DEPTH), "slots overcommitted")
    `ERQ_ASSERT_SAME(a_result_idle, o_res_valid, !o_busy, "result shown while busy")
    `ERQ_ASSERT_NEXT(a_request_answered, accept, o_busy || o_res_valid, "request dropped")

endmodule
